@@ hdl/sct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sorted coordinate table
// Entry layout, request codes, result codes and the command bundle that the
// controller broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int COORD_W  = 8;
    localparam int TAG_W    = 8;
    localparam int RANK_W   = 6;
    localparam int KEY_W    = 2 * COORD_W;
    localparam int GROUP    = 8;
    localparam int NGRP     = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [TAG_W-1:0] TAG_DOT = 8'h2E;
    localparam logic [TAG_W-1:0] TAG_NL  = 8'h0A;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RANK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLANK    = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic              cmp_en;
        logic              shift_en;
        logic              do_ins;
        logic              do_rem;
        t_op               op;
        t_entry            ent;
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  count;
    } t_cell_cmd;

endpackage

@@ hdl/sct_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast key and shifts towards
// either neighbour on insert or remove.
// ----------------------------------------------------------------------------
module sct_cell (
    input  logic                      i_clk,
    input  sct_pkg::t_cell_cmd        i_cmd,
    input  logic [sct_pkg::IDX_W-1:0] i_index,
    input  sct_pkg::t_entry           i_left_entry,
    input  logic                      i_left_lt,
    input  sct_pkg::t_entry           i_right_entry,
    output sct_pkg::t_entry           o_entry,
    output logic                      o_lt,
    output logic                      o_eq,
    output sct_pkg::t_entry           o_hit
);
    import sct_pkg::*;

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   r_sel;

    logic             w_valid;
    logic [KEY_W-1:0] w_key;
    logic [KEY_W-1:0] w_req_key;
    logic             w_rank_hit;

    assign w_valid    = CNT_W'(i_index) < i_cmd.count;
    assign w_key      = {r_entry.row, r_entry.col};
    assign w_req_key  = {i_cmd.ent.row, i_cmd.ent.col};
    assign w_rank_hit = CNT_W'(i_index) == CNT_W'(i_cmd.rank);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_lt <= w_valid && (w_key < w_req_key);
            r_eq <= w_valid && (w_key == w_req_key);
            case (i_cmd.op)
                OP_LOOKUP, OP_REMOVE: r_sel <= w_valid && (w_key == w_req_key);
                OP_RANK:              r_sel <= w_valid && w_rank_hit;
                default:              r_sel <= 1'b0;
            endcase
        end
        if (i_cmd.shift_en && !r_lt) begin
            // slots at or past the insertion point move one place down on insert, one place up on remove
            if (i_cmd.do_ins) begin
                r_entry <= i_left_lt ? i_cmd.ent : i_left_entry;
            end else if (i_cmd.do_rem) begin
                r_entry <= i_right_entry;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_hit   = r_sel ? r_entry : '0;

endmodule

@@ hdl/sct_reduce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_reduce: OR tree over the selected slots
// First level registered per group of slots, second level combined for the
// output register of the controller.
// ----------------------------------------------------------------------------
module sct_reduce (
    input  logic            i_clk,
    input  logic            i_en,
    input  sct_pkg::t_entry i_hit [sct_pkg::DEPTH],
    output sct_pkg::t_entry o_hit
);
    import sct_pkg::*;

    t_entry w_leaf [NGRP][GROUP];
    t_entry n_grp  [NGRP];
    t_entry r_grp  [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        for (genvar j = 0; j < GROUP; j++) begin : g_leaf
            if (g * GROUP + j < DEPTH) begin : g_used
                assign w_leaf[g][j] = i_hit[g * GROUP + j];
            end else begin : g_pad
                assign w_leaf[g][j] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                n_grp[g] = n_grp[g] | w_leaf[g][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_hit = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_hit = o_hit | r_grp[g];
        end
    end

endmodule

@@ hdl/sorted_coordinate_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_coordinate_table_unit: sorted (row, col) table in a row of cells
// Keeps up to DEPTH tagged coordinates in ascending order and serves insert,
// lookup, remove and read-by-rank requests, one result per request.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata fields, lowest bit first
//  ----------+-----+-----------------------------------------------------------
//  s_axis    | in  | op[1:0] row[9:2] col[17:10] tag[25:18] rank[31:26]
//  m_axis    | out | status[2:0] found_tag[10:3] found_row[18:11]
//            |     | found_col[26:19] entry_count[33:27], zero above
//
//  Each request passes accept, compare in every cell, shift plus first OR
//  level and final OR into the output register, in that order.
//  One request is in work at a time; the next is taken as soon as the
//  previous result sits in the output register.
//  A result that is not taken holds the output register and stalls the
//  controller before it overwrites it.
//  Reset (synchronous, active low) clears the entry count and the control
//  state; slot contents are not cleared and only slots below the count are
//  ever observed.
//
module sorted_coordinate_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // op, row, col, tag, rank
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // status, tag, row, col, count, pad
);
    import sct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT,
        S_RED
    } t_state;

    t_state            r_state;
    t_op               r_op;
    t_entry            r_req;
    logic [RANK_W-1:0] r_rank;
    logic [CNT_W-1:0]  r_count;
    t_status           r_status;

    logic              r_out_valid;
    t_status           r_out_status;
    t_entry            r_out_hit;
    logic [CNT_W-1:0]  r_out_count;

    t_cell_cmd         w_cmd;
    t_entry            w_entry [DEPTH];
    t_entry            w_hit   [DEPTH];
    logic [DEPTH-1:0]  w_lt;
    logic [DEPTH-1:0]  w_eq;
    t_entry            w_found;

    logic              w_accept;
    logic              w_out_free;
    logic              w_blank;
    logic              w_dup;
    logic              w_full;
    logic              w_rank_ok;
    logic              w_do_ins;
    logic              w_do_rem;
    t_status           n_status;
    logic [CNT_W-1:0]  n_count;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // decisions made in the shift cycle from the registered compare flags
    assign w_blank   = (r_req.tag == TAG_DOT) || (r_req.tag == TAG_NL);
    assign w_dup     = |w_eq;
    assign w_full    = r_count == CNT_W'(DEPTH);
    assign w_rank_ok = CNT_W'(r_rank) < r_count;
    assign w_do_ins  = (r_op == OP_INSERT) && !w_blank && !w_dup && !w_full;
    assign w_do_rem  = (r_op == OP_REMOVE) && w_dup;

    always_comb begin
        case (r_op)
            OP_INSERT: begin
                if (w_blank)     n_status = ST_BLANK;
                else if (w_dup)  n_status = ST_DUP;
                else if (w_full) n_status = ST_FULL;
                else             n_status = ST_OK;
            end
            OP_LOOKUP, OP_REMOVE: n_status = w_dup ? ST_OK : ST_NOTFOUND;
            OP_RANK:              n_status = w_rank_ok ? ST_OK : ST_NOTFOUND;
            default:              n_status = ST_NOTFOUND;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // broadcast bundle for the row of cells
    always_comb begin
        w_cmd          = '0;
        w_cmd.cmp_en   = r_state == S_CMP;
        w_cmd.shift_en = r_state == S_SHIFT;
        w_cmd.do_ins   = w_do_ins;
        w_cmd.do_rem   = w_do_rem;
        w_cmd.op       = r_op;
        w_cmd.ent      = r_req;
        w_cmd.rank     = r_rank;
        w_cmd.count    = r_count;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_left;
        logic   w_left_lt;
        t_entry w_right;

        if (i == 0) begin : g_first
            // nothing sits before the head: on insert it takes the new entry when it shifts
            assign w_left    = r_req;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[i-1];
            assign w_left_lt = w_lt[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            // tail keeps its own value on remove; it falls outside the count
            assign w_right = w_entry[i];
        end else begin : g_body
            assign w_right = w_entry[i+1];
        end

        sct_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_index       (IDX_W'(i)),
            .i_left_entry  (w_left),
            .i_left_lt     (w_left_lt),
            .i_right_entry (w_right),
            .o_entry       (w_entry[i]),
            .o_lt          (w_lt[i]),
            .o_eq          (w_eq[i]),
            .o_hit         (w_hit[i])
        );
    end

    // selected slot is sampled before the shift lands, so remove reports
    // the entry it drops
    sct_reduce u_reduce (
        .i_clk (i_clk),
        .i_en  (r_state == S_SHIFT),
        .i_hit (w_hit),
        .o_hit (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a fresh result, else drop the one just taken
            if (r_state == S_RED && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= t_op'(i_s_axis_tdata[1:0]);
                        r_req.row <= i_s_axis_tdata[9:2];
                        r_req.col <= i_s_axis_tdata[17:10];
                        r_req.tag <= i_s_axis_tdata[25:18];
                        r_rank    <= i_s_axis_tdata[31:26];
                        r_state   <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_count  <= n_count;
                    r_status <= n_status;
                    r_state  <= S_RED;
                end
                S_RED: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_hit    <= w_found;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_count, r_out_hit.col, r_out_hit.row,
                              r_out_hit.tag, r_out_status};

endmodule

@@ bench/sct_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_table_checker: result checker for the sorted coordinate table
// Watches both stream channels, keeps its own sorted copy of the table,
// works out the result of every accepted request and compares each result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sct_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,    // op, row, col, tag, rank
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // status, tag, row, col, count, pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_accepted,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_peak_fill
);
    import sct_pkg::*;

    t_entry      shadow_tbl [DEPTH];
    int          shadow_count;
    logic [39:0] expected_results [$];
    logic [39:0] want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_accepted   = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_peak_fill  = 0;
        shadow_count = 0;
    end

    // Apply one request to the shadow table and return the packed result.
    function automatic logic [39:0] predict_table_op(input logic [31:0] req);
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [5:0]       rank;
        t_entry           hit_ent;
        t_status          st;
        int               pos;
        int               i;
        logic             present;
        op      = t_op'(req[1:0]);
        key     = {req[9:2], req[17:10]};
        tag     = req[25:18];
        rank    = req[31:26];
        hit_ent = '0;
        st      = ST_OK;
        pos     = 0;
        while (pos < shadow_count && {shadow_tbl[pos].row, shadow_tbl[pos].col} < key)
            pos++;
        present = (pos < shadow_count) && ({shadow_tbl[pos].row, shadow_tbl[pos].col} == key);
        case (op)
            OP_INSERT: begin
                // blank tag wins over duplicate, duplicate over full
                if (tag == TAG_DOT || tag == TAG_NL) begin
                    st = ST_BLANK;
                end else if (present) begin
                    st = ST_DUP;
                end else if (shadow_count == DEPTH) begin
                    st = ST_FULL;
                end else begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_tbl[i] = shadow_tbl[i-1];
                    shadow_tbl[pos] = {key, tag};
                    shadow_count++;
                end
            end
            OP_LOOKUP: begin
                if (present)
                    hit_ent = shadow_tbl[pos];
                else
                    st = ST_NOTFOUND;
            end
            OP_REMOVE: begin
                if (present) begin
                    hit_ent = shadow_tbl[pos];
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_tbl[i] = shadow_tbl[i+1];
                    shadow_count--;
                end else begin
                    st = ST_NOTFOUND;
                end
            end
            OP_RANK: begin
                if (int'(rank) < shadow_count)
                    hit_ent = shadow_tbl[rank];
                else
                    st = ST_NOTFOUND;
            end
        endcase
        if (st == ST_FULL)
            o_full_seen++;
        if (shadow_count > o_peak_fill)
            o_peak_fill = shadow_count;
        return {6'b0, 7'(shadow_count), hit_ent.col, hit_ent.row, hit_ent.tag, st};
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // results first: a request taken at this edge cannot answer yet
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with no request outstanding, expected none, actual 0x%h",
                             $time, i_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status",      32'(want[2:0]),   32'(i_m_tdata[2:0]));
                    compare_field("found_tag",   32'(want[10:3]),  32'(i_m_tdata[10:3]));
                    compare_field("found_row",   32'(want[18:11]), 32'(i_m_tdata[18:11]));
                    compare_field("found_col",   32'(want[26:19]), 32'(i_m_tdata[26:19]));
                    compare_field("entry_count", 32'(want[33:27]), 32'(i_m_tdata[33:27]));
                    compare_field("padding",     32'(want[39:34]), 32'(i_m_tdata[39:34]));
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_table_op(i_s_tdata));
                o_accepted++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/tb_sorted_coordinate_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_coordinate_table_unit: testbench of the sorted coordinate table
// Drives directed and random insert, lookup, remove and read-by-rank requests
// with random gaps and back-pressure; the checker beside the block predicts
// and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_coordinate_table_unit;
    import sct_pkg::*;

    localparam int LIMIT_NS = 20_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int fail_count;
    int pending;
    int accepted;
    int checked;
    int full_seen;
    int peak_fill;

    // stimulus bookkeeping: keys recently inserted, used to aim at hits
    logic [15:0] live_keys [$];
    int          n_sent     = 0;
    bit          src_steady = 1'b0;
    bit          snk_steady = 1'b0;
    int          snk_hold   = 0;

    always #6 clk = ~clk;

    sorted_coordinate_table_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    sct_table_checker u_table_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_accepted   (accepted),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_peak_fill  (peak_fill)
    );

    // Result sink: hold tready low for short or occasionally long stalls,
    // or keep it high throughout a steady stretch.
    always @(posedge clk) begin
        if (snk_hold == 0 && !snk_steady && $urandom_range(0, 99) < 25)
            snk_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
        if (snk_hold > 0) begin
            snk_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int src_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (src_steady || sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Half the time reuse a live key, else a crowded corner of the key space,
    // else anything at all.
    function automatic logic [15:0] pick_key();
        int         sel;
        logic [7:0] row;
        logic [7:0] col;
        sel = $urandom_range(0, 99);
        if (sel < 50 && live_keys.size() > 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (sel < 85) begin
            row = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                       : 8'(8'hFC + $urandom_range(0, 3));
            col = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                       : 8'(8'hFC + $urandom_range(0, 3));
            return {row, col};
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_tag();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return TAG_DOT;
        if (sel < 12)
            return TAG_NL;
        return 8'($urandom);
    endfunction

    function automatic logic [5:0] pick_rank();
        if ($urandom_range(0, 1))
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, live_keys.size() < 58 ? live_keys.size() + 5 : 63));
    endfunction

    // Present one request and hold it until the block takes it. Drop tvalid
    // only when a gap follows, so a back-to-back request keeps it high.
    task automatic issue(input t_op op, input logic [7:0] row, input logic [7:0] col,
                         input logic [7:0] tag, input logic [5:0] rank);
        int gap;
        int j;
        gap = src_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rank, tag, col, row, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        if (op == OP_INSERT) begin
            live_keys.push_back({row, col});
            if (live_keys.size() > 96)
                void'(live_keys.pop_front());
        end else if (op == OP_REMOVE) begin
            for (j = 0; j < live_keys.size(); j++) begin
                if (live_keys[j] == {row, col}) begin
                    live_keys.delete(j);
                    break;
                end
            end
        end
    endtask

    // Weighted random mix; whatever the weights leave over goes to read-rank.
    task automatic random_requests(input int n, input int w_ins, input int w_lkp,
                                   input int w_rem);
        int          i;
        int          sel;
        t_op         op;
        logic [15:0] key;
        for (i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                src_steady = ($urandom_range(0, 3) == 0);
                snk_steady = ($urandom_range(0, 3) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < w_ins)
                op = OP_INSERT;
            else if (sel < w_ins + w_lkp)
                op = OP_LOOKUP;
            else if (sel < w_ins + w_lkp + w_rem)
                op = OP_REMOVE;
            else
                op = OP_RANK;
            key = pick_key();
            issue(op, key[15:8], key[7:0], pick_tag(), pick_rank());
        end
    endtask

    // Inserts with distinct columns, enough to push the table past full.
    task automatic fill_table(input int n);
        int i;
        for (i = 0; i < n; i++)
            issue(OP_INSERT, 8'($urandom), 8'(i), 8'($urandom), 6'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of the key, blank tags, duplicates, hits and misses
        issue(OP_INSERT, 8'h00, 8'h00, 8'hFF, 6'h00);
        issue(OP_INSERT, 8'hFF, 8'hFF, 8'h00, 6'h3F);
        issue(OP_INSERT, 8'h00, 8'hFF, 8'h80, 6'h15);
        issue(OP_INSERT, 8'hFF, 8'h00, 8'h7F, 6'h2A);
        issue(OP_INSERT, 8'h80, 8'h80, TAG_DOT, 6'h00);
        issue(OP_INSERT, 8'h80, 8'h80, TAG_NL, 6'h00);
        issue(OP_INSERT, 8'h00, 8'h00, 8'h41, 6'h00);
        issue(OP_INSERT, 8'hFF, 8'hFF, TAG_DOT, 6'h00);
        issue(OP_LOOKUP, 8'hFF, 8'h00, 8'hA5, 6'h3F);
        issue(OP_LOOKUP, 8'h01, 8'h01, 8'h00, 6'h00);
        issue(OP_RANK,   8'hFF, 8'hFF, 8'hFF, 6'd0);
        issue(OP_RANK,   8'h00, 8'h00, 8'h00, 6'd3);
        issue(OP_RANK,   8'h00, 8'h00, 8'h00, 6'd4);
        issue(OP_RANK,   8'h00, 8'h00, 8'h00, 6'd63);
        issue(OP_REMOVE, 8'h00, 8'hFF, 8'h00, 6'h00);
        issue(OP_REMOVE, 8'h00, 8'hFF, 8'hFF, 6'h3F);
        issue(OP_LOOKUP, 8'h00, 8'hFF, 8'h00, 6'h00);
        issue(OP_RANK,   8'h00, 8'h00, 8'h00, 6'd1);
        issue(OP_INSERT, 8'h55, 8'hAA, 8'hAA, 6'h15);
        issue(OP_INSERT, 8'hAA, 8'h55, 8'h55, 6'h2A);
        issue(OP_LOOKUP, 8'hAA, 8'h55, 8'h00, 6'h00);
        issue(OP_REMOVE, 8'h00, 8'h00, 8'h00, 6'h00);
        issue(OP_REMOVE, 8'hFF, 8'hFF, 8'h00, 6'h00);

        // fill to the brim, churn, drain, churn, fill again and churn, without idling
        fill_table(90);
        random_requests(400, 45, 20, 15);
        random_requests(150, 10, 15, 60);
        random_requests(400, 30, 25, 25);
        fill_table(80);
        random_requests(230, 30, 25, 25);

        s_tvalid <= 1'b0;
        src_steady = 1'b0;
        snk_steady = 1'b0;

        // let the checker catch up, then allow the pipeline to settle
        @(posedge clk);
        while (accepted != n_sent || pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d requests in directed, fill, drain and mixed phases; %0d results checked",
                 accepted, checked);
        $display("Table-full rejections %0d, peak occupancy %0d of %0d slots",
                 full_seen, peak_fill, DEPTH);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Timeout after %0d ns with %0d results outstanding", LIMIT_NS, pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
